### rtl/circular_queue_with_drain_top_defines.svh
// Assertion macros shared by the circular queue RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef CIRCULAR_QUEUE_WITH_DRAIN_TOP_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_DRAIN_TOP_DEFINES_SVH

// Same-cycle implication, off during reset
`define CQD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cqd: same-cycle check failed");

// Next-cycle implication, off during reset
`define CQD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cqd: next-cycle check failed");

`endif

### rtl/cqd_pkg.sv
// Shared types and codes for the circular queue with drain.
// No dependencies; imported by the top, front and back modules.
package cqd_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CAP_W     = 5;
  localparam int DATA_W    = 32;
  localparam int CMDQ_SIZE = 2;

  // Operation codes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_DRAIN   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_ENQUEUED  = 2'd0;
  localparam logic [1:0] ST_REMOVED   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // Command handed from the front to the back
  typedef struct packed {
    logic                     valid;
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

### rtl/circular_queue_with_drain_top.sv
// Path: an accepted command waits in a front queue slot; the back end takes it and registers its result onto done.
// Throughput: enqueue and dequeue one per cycle while no drain is running; a drain
// emits one removed value per cycle until the queue is empty, paced by the RAM read port.
// busy rises only when the two-entry command queue fills behind a drain.
// Reset (synchronous): queue empty, pointers zero, capacity 16, no clearing pass.
// Top level of the circular queue; depends on cqd_pkg, cqd_front and cqd_back.
module circular_queue_with_drain_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation,
  input  logic signed [cqd_pkg::DATA_W-1:0] push_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cqd_pkg::CAP_W-1:0]         capacity,
  output logic                              done,
  output logic signed [cqd_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                        status,
  output logic                              last
);
  import cqd_pkg::*;

  cmd_t cmd;
  logic take;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  cqd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .push_value (push_value),
    .cmd        (cmd),
    .take       (take)
  );

  cqd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .take         (take),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (capacity),
    .done         (done),
    .pop_value    (pop_value),
    .status       (status),
    .last         (last)
  );

endmodule

### rtl/cqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/cqd_front.sv
// Front end: accepts commands, drops unused codes, holds a short command queue.
// Depends on cqd_pkg and the assertion macro header.
`include "circular_queue_with_drain_top_defines.svh"

module cqd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation,
  input  logic signed [cqd_pkg::DATA_W-1:0] push_value,
  output cqd_pkg::cmd_t                     cmd,
  input  logic                              take
);
  import cqd_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_SIZE);
  localparam int CNT_W = $clog2(CMDQ_SIZE + 1);

  logic [1:0]               slot_op    [CMDQ_SIZE];
  logic signed [DATA_W-1:0] slot_value [CMDQ_SIZE];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         count;
  logic                     push;
  logic                     pop;

  // Classify: only real operations enter the queue
  assign busy = (count == CNT_W'(CMDQ_SIZE));
  assign push = start && !busy && (operation != OP_NONE);
  assign pop  = take && (count != '0);

  assign cmd.valid = (count != '0);
  assign cmd.op    = slot_op[rd_ptr];
  assign cmd.value = slot_value[rd_ptr];

  // Store the command payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_op[wr_ptr]    <= operation;
      slot_value[wr_ptr] <= push_value;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `CQD_ASSERT_NEXT(a_push_lands, clk, rst, push, count != '0)

endmodule

### rtl/cqd_back.sv
// Back end: owns the ring pointers and capacity, executes commands, forms results.
// Depends on cqd_pkg, cqd_ram and the assertion macro header.
`include "circular_queue_with_drain_top_defines.svh"

module cqd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  cqd_pkg::cmd_t                     cmd,
  output logic                              take,
  input  logic                              cfg_we,
  input  logic [cqd_pkg::CAP_W-1:0]         cfg_capacity,
  output logic                              done,
  output logic signed [cqd_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                        status,
  output logic                              last
);
  import cqd_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic              state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic              is_empty, is_empty_next;
  logic [CAP_W-1:0]  capacity, capacity_next;
  logic              resp_valid, resp_valid_next;
  logic [1:0]        resp_status, resp_status_next;
  logic              resp_last, resp_last_next;
  logic              resp_from_ram, resp_from_ram_next;
  logic              full;
  logic              ram_we;
  logic [IDX_W-1:0]  head_adv;
  logic [IDX_W-1:0]  tail_adv;
  logic              drained;
  logic [DATA_W-1:0] rdata;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(idx) + CAP_W'(1);
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [CAP_W-1:0] clamp_capacity(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] c;
    c = v;
    if (c == '0) c = CAP_W'(1);
    if (c > CAP_W'(DEPTH)) c = CAP_W'(DEPTH);
    return c;
  endfunction

  assign full     = !is_empty && (head == tail);
  assign head_adv = ring_next(head, capacity);
  assign tail_adv = ring_next(tail, capacity);
  assign drained  = (head_adv == tail);
  assign take     = (state == S_IDLE) && cmd.valid;

  cqd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (cmd.value),
    .raddr (head),
    .rdata (rdata)
  );

  // Execute the current command and plan the next result
  always_comb begin
    state_next         = state;
    head_next          = head;
    tail_next          = tail;
    is_empty_next      = is_empty;
    capacity_next      = capacity;
    ram_we             = 1'b0;
    resp_valid_next    = 1'b0;
    resp_status_next   = ST_ENQUEUED;
    resp_last_next     = 1'b1;
    resp_from_ram_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          unique case (cmd.op)
            OP_ENQUEUE: begin
              resp_valid_next = 1'b1;
              if (full) begin
                resp_status_next = ST_OVERFLOW;
              end else begin
                ram_we        = 1'b1;
                tail_next     = tail_adv;
                is_empty_next = 1'b0;
              end
            end
            OP_DEQUEUE: begin
              resp_valid_next = 1'b1;
              if (is_empty) begin
                resp_status_next = ST_UNDERFLOW;
              end else begin
                head_next          = head_adv;
                is_empty_next      = drained;
                resp_status_next   = ST_REMOVED;
                resp_from_ram_next = 1'b1;
              end
            end
            OP_DRAIN: begin
              if (!is_empty) begin
                head_next          = head_adv;
                is_empty_next      = drained;
                resp_valid_next    = 1'b1;
                resp_status_next   = ST_REMOVED;
                resp_from_ram_next = 1'b1;
                resp_last_next     = drained;
                state_next         = drained ? S_IDLE : S_DRAIN;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        head_next          = head_adv;
        is_empty_next      = drained;
        resp_valid_next    = 1'b1;
        resp_status_next   = ST_REMOVED;
        resp_from_ram_next = 1'b1;
        resp_last_next     = drained;
        state_next         = drained ? S_IDLE : S_DRAIN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Capacity write takes effect only on an empty queue
    if (cfg_we && is_empty) begin
      capacity_next = clamp_capacity(cfg_capacity);
      head_next     = '0;
      tail_next     = '0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      is_empty   <= 1'b1;
      capacity   <= CAP_W'(DEPTH);
      resp_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      is_empty   <= is_empty_next;
      capacity   <= capacity_next;
      resp_valid <= resp_valid_next;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    resp_status   <= resp_status_next;
    resp_last     <= resp_last_next;
    resp_from_ram <= resp_from_ram_next;
  end

  assign done      = resp_valid;
  assign status    = resp_status;
  assign last      = resp_last;
  assign pop_value = resp_from_ram ? $signed(rdata) : '0;

  `CQD_ASSERT_IMPL(a_empty_ptrs, clk, rst, is_empty, head == tail)
  `CQD_ASSERT_IMPL(a_zero_value, clk, rst, done && (status != ST_REMOVED), pop_value == '0)
  `CQD_ASSERT_IMPL(a_drain_nonempty, clk, rst, state == S_DRAIN, !is_empty)
  `CQD_ASSERT_NEXT(a_drain_emits, clk, rst, state == S_DRAIN, resp_valid)

endmodule

### sim/tb_circular_queue_with_drain_top.sv
// Self-checking testbench for circular_queue_with_drain_top: directed edge cases, then
// random command traffic over several capacities, checked against an in-bench queue mirror.
// Depends on cqd_pkg and the circular_queue_with_drain_top RTL.
module tb_circular_queue_with_drain_top;
  import cqd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 16;
  localparam int PHASE_ITEMS   = 46;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic                     last;
  } response_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               operation;
  logic signed [DATA_W-1:0] push_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         capacity;
  logic                     done;
  logic signed [DATA_W-1:0] pop_value;
  logic [1:0]               status;
  logic                     last;

  // Mirror of the queue contents and pointers
  logic signed [DATA_W-1:0] mirror_ring [DEPTH];
  int unsigned              mirror_head;
  int unsigned              mirror_tail;
  int unsigned              mirror_cap;
  bit                       mirror_empty;

  response_t   awaited_responses [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned burst_left = 0;

  always #6 clk = ~clk;

  circular_queue_with_drain_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .push_value (push_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .done       (done),
    .pop_value  (pop_value),
    .status     (status),
    .last       (last)
  );

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%s", msg);
  endfunction

  function automatic void expect_response(logic signed [DATA_W-1:0] v, logic [1:0] st,
                                          logic lst);
    response_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    awaited_responses.push_back(r);
  endfunction

  function automatic int unsigned ring_advance(int unsigned idx);
    return (idx + 1 >= mirror_cap) ? 0 : idx + 1;
  endfunction

  function automatic logic signed [DATA_W-1:0] pop_oldest();
    logic signed [DATA_W-1:0] v;
    v = mirror_ring[mirror_head];
    mirror_head = ring_advance(mirror_head);
    if (mirror_head == mirror_tail) mirror_empty = 1'b1;
    return v;
  endfunction

  // Update the mirror for one accepted command and queue the responses it causes
  function automatic void apply_queue_command(logic [1:0] op, logic signed [DATA_W-1:0] val);
    int                       n;
    logic signed [DATA_W-1:0] v;
    case (op)
      OP_ENQUEUE: begin
        if (!mirror_empty && mirror_head == mirror_tail) begin
          expect_response('0, ST_OVERFLOW, 1'b1);
        end else begin
          mirror_ring[mirror_tail] = val;
          mirror_tail = ring_advance(mirror_tail);
          mirror_empty = 1'b0;
          expect_response('0, ST_ENQUEUED, 1'b1);
        end
      end
      OP_DEQUEUE: begin
        if (mirror_empty) begin
          expect_response('0, ST_UNDERFLOW, 1'b1);
        end else begin
          v = pop_oldest();
          expect_response(v, ST_REMOVED, 1'b1);
        end
      end
      OP_DRAIN: begin
        n = 0;
        while (!mirror_empty && n < DRAIN_LIMIT) begin
          v = pop_oldest();
          n++;
          expect_response(v, ST_REMOVED, mirror_empty || n == DRAIN_LIMIT);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Capacity changes only on an empty queue; zero maps to one, above DEPTH to DEPTH
  function automatic void apply_capacity_write(logic [CAP_W-1:0] v);
    if (!mirror_empty) return;
    mirror_cap  = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : v);
    mirror_head = 0;
    mirror_tail = 0;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    response_t want;
    if (!rst && done) begin
      if (awaited_responses.size() == 0) begin
        log_mismatch($sformatf("unexpected result: value %0d status %0d last %0b",
                               pop_value, status, last));
      end else begin
        want = awaited_responses.pop_front();
        if (pop_value !== want.value || status !== want.status || last !== want.last)
          log_mismatch($sformatf("mismatch: value %0d/%0d status %0d/%0d last %0b/%0b (exp/act)",
                                 want.value, pop_value, want.status, status,
                                 want.last, last));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_circular_queue_with_drain_top: FAIL");
      $finish;
    end
  end

  // Drop start at the current idle rate, with occasional gapless bursts
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 99) < 5) begin
      burst_left = $urandom_range(8, 20);
    end else if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold the command until the transfer, then predict; start stays high for the caller
  task automatic send_cmd(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
    sender_gap();
    start     <= 1'b1;
    operation <= op;
    push_value <= val;
    do @(posedge clk); while (busy);
    apply_queue_command(op, val);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    capacity  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_capacity_write(v);
  endtask

  // Empty queue cases, extreme values, oldest-first order at reset capacity
  task automatic test_empty_and_extremes();
    idle_pct = 0;
    send_cmd(OP_DEQUEUE, 32'h1234_5678);
    send_cmd(OP_DRAIN, 32'h0);
    send_cmd(OP_NONE, 32'h5555_5555);
    send_cmd(OP_ENQUEUE, 32'h7fff_ffff);
    send_cmd(OP_ENQUEUE, 32'h8000_0000);
    send_cmd(OP_ENQUEUE, 32'h0000_0000);
    send_cmd(OP_ENQUEUE, 32'hffff_ffff);
    send_cmd(OP_DEQUEUE, 32'h0);
    send_cmd(OP_DRAIN, 32'h0);
  endtask

  // Full queue, pointer wrap, and a capacity write on a non-empty queue
  task automatic test_full_and_wrap();
    write_capacity(5'd2);
    send_cmd(OP_ENQUEUE, 32'h0000_00a1);
    send_cmd(OP_ENQUEUE, 32'h0000_00b2);
    send_cmd(OP_ENQUEUE, 32'h0000_00c3);
    send_cmd(OP_DEQUEUE, 32'h0);
    send_cmd(OP_ENQUEUE, 32'h0000_00d4);
    send_cmd(OP_DRAIN, 32'h0);
    send_cmd(OP_ENQUEUE, 32'h0000_00e5);
    write_capacity(5'd1);
    send_cmd(OP_ENQUEUE, 32'h0000_00f6);
    send_cmd(OP_ENQUEUE, 32'h0000_0107);
    send_cmd(OP_NONE, 32'hffff_ffff);
    send_cmd(OP_DRAIN, 32'h0);
  endtask

  // Capacity zero acts as one; capacity above DEPTH acts as DEPTH
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_cmd(OP_ENQUEUE, 32'h0bad_cafe);
    send_cmd(OP_ENQUEUE, 32'h0000_0001);
    send_cmd(OP_DEQUEUE, 32'h0);
    send_cmd(OP_DEQUEUE, 32'h0);
    write_capacity(5'd31);
    send_cmd(OP_ENQUEUE, 32'h8000_0001);
    send_cmd(OP_DRAIN, 32'h0);
  endtask

  // Random command mix per capacity, ending each phase with a drain
  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [10] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1,
                                    5'd7, 5'd17, 5'd2, 5'd16, 5'd5};
    int unsigned      rates [3] = '{0, 71, 14};
    int unsigned      enq_w;
    int unsigned      roll;
    int               sent;
    logic [1:0]       op;
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      idle_pct = rates[p % 3];
      enq_w = $urandom_range(45, 75);
      sent = 0;
      while (sent < PHASE_ITEMS - 1) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) op = OP_NONE;
        else if (roll < 4 + enq_w) op = OP_ENQUEUE;
        else if (roll < 96) op = OP_DEQUEUE;
        else op = OP_DRAIN;
        send_cmd(op, pick_word());
        if (op != OP_NONE) sent++;
      end
      send_cmd(OP_DRAIN, pick_word());
    end
  endtask

  initial begin
    int unsigned guard;
    rst        <= 1'b1;
    start      <= 1'b0;
    operation  <= OP_NONE;
    push_value <= '0;
    cfg_valid  <= 1'b0;
    capacity   <= 5'd16;
    for (int i = 0; i < DEPTH; i++) mirror_ring[i] = '0;
    mirror_head  = 0;
    mirror_tail  = 0;
    mirror_cap   = DEPTH;
    mirror_empty = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_extremes();
    test_full_and_wrap();
    test_capacity_limits();
    test_random_traffic();

    // Let outstanding results arrive, then settle
    start <= 1'b0;
    guard = 0;
    while (awaited_responses.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_responses.size() != 0)
      log_mismatch($sformatf("%0d expected results never arrived", awaited_responses.size()));

    if (mismatches == 0) begin
      $display("tb_circular_queue_with_drain_top: PASS");
    end else begin
      $display("tb_circular_queue_with_drain_top: FAIL");
    end
    $finish;
  end

endmodule
